// ===== src/gpr_pkg.sv =====
// ----------------------------------------------------------------------------
// GPIO port register package
// Shared types, register codes and field helpers for the GPIO port block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpr_pkg;

    localparam int PIN_COUNT = 16;

    localparam logic [15:0] PIN_MASK = 16'((32'h1 << PIN_COUNT) - 32'h1);

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [3:0] REG_MODE     = 4'd0;
    localparam logic [3:0] REG_OTYPE    = 4'd1;
    localparam logic [3:0] REG_SPEED    = 4'd2;
    localparam logic [3:0] REG_PULL     = 4'd3;
    localparam logic [3:0] REG_INDATA   = 4'd4;
    localparam logic [3:0] REG_OUTDATA  = 4'd5;
    localparam logic [3:0] REG_SETRESET = 4'd6;
    localparam logic [3:0] REG_LOCK     = 4'd7;
    localparam logic [3:0] REG_AFL      = 4'd8;
    localparam logic [3:0] REG_AFH      = 4'd9;

    // One bus access as held in the input register.
    typedef struct packed {
        logic        wr;
        logic [3:0]  idx;
        logic [31:0] data;
        logic [15:0] levels;
    } access_t;

    // Request from the datapath to the lock sequencer.
    typedef struct packed {
        logic        fire;
        logic        wr;
        logic        key;
        logic [15:0] pins;
    } lock_req_t;

    // Lock state as seen by the register file.
    typedef struct packed {
        logic        key_bit;
        logic [15:0] locked_pins;
    } lock_stat_t;

    // Two mask bits per pin.
    function automatic logic [31:0] spread2(input logic [15:0] m);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 16; i++)
        begin
            r[2*i +: 2] = {2{m[i]}};
        end
        return r;
    endfunction

    // Four mask bits per pin, eight pins.
    function automatic logic [31:0] spread4(input logic [7:0] m);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            r[4*i +: 4] = {4{m[i]}};
        end
        return r;
    endfunction

    function automatic logic [31:0] merge(input logic [31:0] old_val,
                                          input logic [31:0] new_val,
                                          input logic [31:0] wm);
        return (old_val & ~wm) | (new_val & wm);
    endfunction

endpackage

`default_nettype wire

// ===== src/gpr_in_if.sv =====
// ----------------------------------------------------------------------------
// GPIO port access channel
// Valid/ready channel carrying one register access.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpr_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [15:0] pin_levels;

    modport source (output valid, cmd, reg_index, write_data, pin_levels, input ready);
    modport sink   (input valid, cmd, reg_index, write_data, pin_levels, output ready);
endinterface

`default_nettype wire

// ===== src/gpr_out_if.sv =====
// ----------------------------------------------------------------------------
// GPIO port result channel
// Valid/ready channel carrying one access result.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [15:0] pin_drive;
    logic        lock_active;

    modport source (output valid, read_data, pin_drive, lock_active, input ready);
    modport sink   (input valid, read_data, pin_drive, lock_active, output ready);
endinterface

`default_nettype wire

// ===== src/gpr_lock.sv =====
// ----------------------------------------------------------------------------
// GPIO port lock sequencer
// Tracks the lock key sequence and holds the locked pin mask and lock bit.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_lock
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gpr_pkg::lock_req_t req,
    output gpr_pkg::lock_stat_t     stat,
    output logic                    key_bit_next
);
    import gpr_pkg::*;

    typedef enum logic [1:0] {
        LK_IDLE,
        LK_KEY1,
        LK_KEY0,
        LK_ARMED
    } lock_state_t;

    lock_state_t state_reg, state_next;
    logic        key_bit_reg;
    logic [15:0] pins_reg, pins_next;

    always_comb
    begin
        state_next   = state_reg;
        key_bit_next = key_bit_reg;
        pins_next    = pins_reg;
        if (req.fire)
        begin
            if (key_bit_reg)
            begin
                state_next = LK_IDLE;
            end
            else if (!req.wr)
            begin
                if (state_reg == LK_ARMED)
                begin
                    key_bit_next = 1'b1;
                end
                state_next = LK_IDLE;
            end
            else if (state_reg == LK_KEY1 && !req.key && req.pins == pins_reg)
            begin
                state_next = LK_KEY0;
            end
            else if (state_reg == LK_KEY0 && req.key && req.pins == pins_reg)
            begin
                state_next = LK_ARMED;
            end
            else
            begin
                // Any other write restarts the sequence with its own pins.
                pins_next  = req.pins;
                state_next = req.key ? LK_KEY1 : LK_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= LK_IDLE;
            key_bit_reg <= 1'b0;
            pins_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            key_bit_reg <= key_bit_next;
            pins_reg    <= pins_next;
        end
    end

    assign stat.key_bit     = key_bit_reg;
    assign stat.locked_pins = pins_reg;

    // Once set, the lock holds until reset.
    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        key_bit_reg |=> key_bit_reg)
        else $error("lock bit cleared without reset");

    // The lock is only taken by a read that follows a complete key sequence.
    a_lock_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(key_bit_reg) |-> $past(req.fire && !req.wr && state_reg == LK_ARMED))
        else $error("lock bit set without a complete key sequence");

    // No sequence is in progress while locked.
    a_idle_when_locked: assert property (@(posedge clk) disable iff (!rst_n)
        key_bit_reg |-> state_reg == LK_IDLE)
        else $error("key sequence in progress while locked");

endmodule

`default_nettype wire

// ===== src/gpr_regfile.sv =====
// ----------------------------------------------------------------------------
// GPIO port register file
// Configuration words and output latch, with write masking and read mux.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_regfile
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire gpr_pkg::access_t    acc,
    input  wire gpr_pkg::lock_stat_t lock_stat,
    output logic [31:0]              read_data,
    output logic [15:0]              latch_next
);
    import gpr_pkg::*;

    logic [31:0] mode_reg, mode_next;
    logic [15:0] otype_reg, otype_next;
    logic [31:0] speed_reg, speed_next;
    logic [31:0] pull_reg, pull_next;
    logic [31:0] afl_reg, afl_next;
    logic [31:0] afh_reg, afh_next;
    logic [15:0] latch_reg;
    logic [15:0] wmask;
    logic [31:0] wmask2;

    // Pins frozen by the lock keep their configuration fields.
    assign wmask  = PIN_MASK & ~(lock_stat.key_bit ? lock_stat.locked_pins : 16'h0000);
    assign wmask2 = spread2(wmask);

    always_comb
    begin
        mode_next  = mode_reg;
        otype_next = otype_reg;
        speed_next = speed_reg;
        pull_next  = pull_reg;
        afl_next   = afl_reg;
        afh_next   = afh_reg;
        latch_next = latch_reg;
        if (fire && acc.wr == CMD_WRITE)
        begin
            unique case (acc.idx)
                REG_MODE:     mode_next  = merge(mode_reg, acc.data, wmask2);
                REG_OTYPE:    otype_next = (otype_reg & ~wmask) | (acc.data[15:0] & wmask);
                REG_SPEED:    speed_next = merge(speed_reg, acc.data, wmask2);
                REG_PULL:     pull_next  = merge(pull_reg, acc.data, wmask2);
                REG_OUTDATA:  latch_next = acc.data[15:0] & PIN_MASK;
                REG_SETRESET: latch_next = ((latch_reg & ~acc.data[31:16]) | acc.data[15:0])
                                           & PIN_MASK;
                REG_AFL:      afl_next   = merge(afl_reg, acc.data, spread4(wmask[7:0]));
                REG_AFH:      afh_next   = merge(afh_reg, acc.data, spread4(wmask[15:8]));
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        read_data = '0;
        if (acc.wr == CMD_READ)
        begin
            unique case (acc.idx)
                REG_MODE:    read_data = mode_reg;
                REG_OTYPE:   read_data = {16'h0000, otype_reg};
                REG_SPEED:   read_data = speed_reg;
                REG_PULL:    read_data = pull_reg;
                REG_INDATA:  read_data = {16'h0000, acc.levels & PIN_MASK};
                REG_OUTDATA: read_data = {16'h0000, latch_reg};
                REG_LOCK:    read_data = {15'h0000, lock_stat.key_bit, lock_stat.locked_pins};
                REG_AFL:     read_data = afl_reg;
                REG_AFH:     read_data = afh_reg;
                default:     read_data = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= '0;
            otype_reg <= '0;
            speed_reg <= '0;
            pull_reg  <= '0;
            afl_reg   <= '0;
            afh_reg   <= '0;
            latch_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            otype_reg <= otype_next;
            speed_reg <= speed_next;
            pull_reg  <= pull_next;
            afl_reg   <= afl_next;
            afh_reg   <= afh_next;
            latch_reg <= latch_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/gpio_port_registers_top.sv =====
// ----------------------------------------------------------------------------
// GPIO port registers, top level
// Sixteen-pin GPIO port register block behind a valid/ready access channel.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   -------  ---------  -----------------------------------------------------
//   req      in         cmd, reg_index, write_data, pin_levels (one access)
//   rsp      out        read_data, pin_drive, lock_active (one result)
//
// Each access is held in the input register and is then evaluated
// against the register file and lock sequencer, whose state updates on the
// same edge that loads the result register. While rsp does not stall, one
// transfer per cycle is sustained, as the next access needs only the state
// the previous one left on that edge.
// Reset clears every register of the port, the lock included, and both
// pipeline valid flags. A stall on rsp holds the result register; the input
// register still takes a transfer if it is empty, and req.ready then drops.
//
`default_nettype none

module gpio_port_registers_top
(
    input  wire logic clk,
    input  wire logic rst_n,
    gpr_in_if.sink    req,
    gpr_out_if.source rsp
);
    import gpr_pkg::*;

    // Input register stage.
    logic       s1_valid_reg;
    access_t    s1_acc_reg;

    // Result register stage.
    logic        out_valid_reg;
    logic [31:0] out_read_data_reg;
    logic [15:0] out_pin_drive_reg;
    logic        out_lock_active_reg;

    logic        advance;
    logic        req_fire;
    lock_req_t   lock_req;
    lock_stat_t  lock_stat;
    logic        key_bit_next;
    logic [31:0] read_data;
    logic [15:0] latch_next;

    // The access in the input register moves on whenever the result register
    // is empty or its contents are taken in this cycle.
    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    assign lock_req.fire = advance && (s1_acc_reg.idx == REG_LOCK);
    assign lock_req.wr   = s1_acc_reg.wr;
    assign lock_req.key  = s1_acc_reg.data[16];
    assign lock_req.pins = s1_acc_reg.data[15:0] & PIN_MASK;

    gpr_lock u_lock
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (lock_req),
        .stat         (lock_stat),
        .key_bit_next (key_bit_next)
    );

    gpr_regfile u_regfile
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .acc        (s1_acc_reg),
        .lock_stat  (lock_stat),
        .read_data  (read_data),
        .latch_next (latch_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_acc_reg.wr     <= req.cmd;
            s1_acc_reg.idx    <= req.reg_index;
            s1_acc_reg.data   <= req.write_data;
            s1_acc_reg.levels <= req.pin_levels;
        end
        if (advance)
        begin
            // Pin drive and lock flag report the state after the access.
            out_read_data_reg   <= read_data;
            out_pin_drive_reg   <= latch_next;
            out_lock_active_reg <= key_bit_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_data   = out_read_data_reg;
    assign rsp.pin_drive   = out_pin_drive_reg;
    assign rsp.lock_active = out_lock_active_reg;

endmodule

`default_nettype wire

// ===== test/gpio_port_registers_top_tb.sv =====
// ----------------------------------------------------------------------------
// GPIO port registers, testbench
// Drives register accesses into the port over the request channel, predicts
// every result from a private copy of the port registers and the lock key
// sequencer, and checks each result transfer field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_port_registers_top_tb;

    import gpr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 16;

    // Position in the lock key sequence.
    typedef enum logic [1:0]
    {
        KEY_IDLE,
        KEY_FIRST,
        KEY_SECOND,
        KEY_THIRD
    } key_step_t;

    // One result as it should leave the port.
    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_drive;
        logic        lock_active;
    } port_result_t;

    logic clk;
    logic rst_n;

    gpr_in_if  req_ch();
    gpr_out_if rsp_ch();

    gpio_port_registers_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted register contents of the port.
    logic [31:0] mode_q;
    logic [15:0] otype_q;
    logic [31:0] speed_q;
    logic [31:0] pull_q;
    logic [31:0] altfunc_q [2];
    logic [15:0] latch_q;
    logic [15:0] lock_pins_q;
    key_step_t   key_step_q;
    logic        lock_on_q;

    port_result_t expected_results [$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  items_sent  = 0;
    int  stall_left  = 0;
    bit  idle_on     = 1'b1;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= CMD_READ;
        req_ch.reg_index  <= REG_MODE;
        req_ch.write_data <= '0;
        req_ch.pin_levels <= '0;
        rsp_ch.ready      <= 1'b0;
    end

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Two mask bits per pin, for the mode, speed and pull words.
    function automatic logic [31:0] pair_mask(input logic [15:0] pins);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < 16; i++)
        begin
            m[2*i +: 2] = {2{pins[i]}};
        end
        return m;
    endfunction

    // Four mask bits per pin, for one alternate-function word.
    function automatic logic [31:0] nibble_mask(input logic [7:0] pins);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            m[4*i +: 4] = {4{pins[i]}};
        end
        return m;
    endfunction

    function automatic logic [31:0] blend_field(input logic [31:0] old_word,
                                                input logic [31:0] new_word,
                                                input logic [31:0] m);
        return (old_word & ~m) | (new_word & m);
    endfunction

    // Moves the lock key sequence on for one access to the lock register.
    function automatic void advance_lock_key(input logic wr, input logic [31:0] d);
        logic [15:0] pins;
        logic        key;
        pins = d[15:0] & PIN_MASK;
        key  = d[16];
        if (lock_on_q)
        begin
            key_step_q = KEY_IDLE;
        end
        else if (!wr)
        begin
            if (key_step_q == KEY_THIRD)
                lock_on_q = 1'b1;
            key_step_q = KEY_IDLE;
        end
        else if (key_step_q == KEY_FIRST && !key && pins == lock_pins_q)
        begin
            key_step_q = KEY_SECOND;
        end
        else if (key_step_q == KEY_SECOND && key && pins == lock_pins_q)
        begin
            key_step_q = KEY_THIRD;
        end
        else
        begin
            lock_pins_q = pins;
            key_step_q  = key ? KEY_FIRST : KEY_IDLE;
        end
    endfunction

    // Applies one access to the predicted registers and gives its result.
    function automatic port_result_t predict_access(input logic wr,
                                                    input logic [3:0] idx,
                                                    input logic [31:0] d,
                                                    input logic [15:0] levels);
        logic [15:0]  wmask;
        logic [31:0]  rd;
        port_result_t r;
        wmask = PIN_MASK & ~(lock_on_q ? lock_pins_q : 16'h0000);
        rd    = '0;
        if (wr == CMD_WRITE)
        begin
            case (idx)
                REG_MODE:     mode_q  = blend_field(mode_q, d, pair_mask(wmask));
                REG_OTYPE:    otype_q = (otype_q & ~wmask) | (d[15:0] & wmask);
                REG_SPEED:    speed_q = blend_field(speed_q, d, pair_mask(wmask));
                REG_PULL:     pull_q  = blend_field(pull_q, d, pair_mask(wmask));
                REG_OUTDATA:  latch_q = d[15:0] & PIN_MASK;
                REG_SETRESET: latch_q = ((latch_q & ~d[31:16]) | d[15:0]) & PIN_MASK;
                REG_LOCK:     advance_lock_key(CMD_WRITE, d);
                REG_AFL:
                    altfunc_q[0] = blend_field(altfunc_q[0], d, nibble_mask(wmask[7:0]));
                REG_AFH:
                    altfunc_q[1] = blend_field(altfunc_q[1], d, nibble_mask(wmask[15:8]));
                default: ;
            endcase
        end
        else
        begin
            case (idx)
                REG_MODE:    rd = mode_q;
                REG_OTYPE:   rd = {16'h0000, otype_q};
                REG_SPEED:   rd = speed_q;
                REG_PULL:    rd = pull_q;
                REG_INDATA:  rd = {16'h0000, levels & PIN_MASK};
                REG_OUTDATA: rd = {16'h0000, latch_q};
                REG_LOCK:
                begin
                    rd = {15'h0000, lock_on_q, lock_pins_q};
                    advance_lock_key(CMD_READ, '0);
                end
                REG_AFL:     rd = altfunc_q[0];
                REG_AFH:     rd = altfunc_q[1];
                default:     rd = '0;
            endcase
        end
        r.read_data   = rd;
        r.pin_drive   = latch_q;
        r.lock_active = lock_on_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h, expected %h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // Offers one access and waits for its transfer; the expectation is worked
    // out at the edge that accepts it, so it sees every earlier access.
    task automatic send_access(input logic wr, input logic [3:0] idx,
                               input logic [31:0] d, input logic [15:0] levels);
        while (idle_on && chance(IDLE_PCT))
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= wr;
        req_ch.reg_index  <= idx;
        req_ch.write_data <= d;
        req_ch.pin_levels <= levels;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_results.push_back(predict_access(wr, idx, d, levels));
        items_sent++;
    endtask

    // Drops valid and holds off until every result has come back.
    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [3:0] random_index();
        if (chance(10))
            return 4'($urandom_range(10, 15));
        return 4'($urandom_range(0, 9));
    endfunction

    // Before the lock is meant to close, a read of the lock register at the
    // last key step is turned into a write so the port stays unlocked.
    task automatic send_random_access(input bit may_lock);
        logic       wr;
        logic [3:0] idx;
        wr  = chance(50) ? CMD_WRITE : CMD_READ;
        idx = random_index();
        if (!may_lock && wr == CMD_READ && idx == REG_LOCK && key_step_q == KEY_THIRD)
            wr = CMD_WRITE;
        send_access(wr, idx, $urandom, 16'($urandom));
    endtask

    task automatic send_other_access();
        logic [3:0] idx;
        idx = random_index();
        if (idx == REG_LOCK)
            idx = REG_INDATA;
        send_access(chance(50) ? CMD_WRITE : CMD_READ, idx, $urandom, 16'($urandom));
    endtask

    // A key sequence with random pins, sometimes spoilt at one or more steps and
    // sometimes with other registers touched in between.
    task automatic send_lock_attempt(input bit may_lock);
        logic [15:0] pins;
        logic [31:0] d;
        pins = 16'($urandom);
        d = $urandom;
        d[16] = 1'b1;
        d[15:0] = pins;
        send_access(CMD_WRITE, REG_LOCK, d, 16'($urandom));
        for (int step = 0; step < 2; step++)
        begin
            if (chance(25))
                send_other_access();
            d = $urandom;
            d[16] = (step == 1);
            d[15:0] = pins;
            if (chance(15))
                d = d ^ (32'h1 << $urandom_range(0, 16));
            send_access(CMD_WRITE, REG_LOCK, d, 16'($urandom));
        end
        if (chance(25))
            send_other_access();
        if (may_lock || key_step_q != KEY_THIRD)
            send_access(CMD_READ, REG_LOCK, $urandom, 16'($urandom));
        else if (chance(60))
            send_access(CMD_WRITE, REG_LOCK, $urandom, 16'($urandom));
    endtask

    task automatic test_register_extremes();
        logic [3:0] regs [6];
        regs = '{REG_MODE, REG_OTYPE, REG_SPEED, REG_PULL, REG_AFL, REG_AFH};
        foreach (regs[i])
        begin
            send_access(CMD_WRITE, regs[i], 32'hFFFF_FFFF, 16'h0000);
            send_access(CMD_READ, regs[i], 32'h0000_0000, 16'hFFFF);
        end
    endtask

    task automatic test_output_latch();
        send_access(CMD_WRITE, REG_OUTDATA, 32'hFFFF_FFFF, 16'h0000);
        send_access(CMD_READ, REG_OUTDATA, 32'h0000_0000, 16'h0000);
        // Clear every pin, then name every pin in both halves: set wins.
        send_access(CMD_WRITE, REG_SETRESET, 32'hFFFF_0000, 16'h0000);
        send_access(CMD_WRITE, REG_SETRESET, 32'hFFFF_FFFF, 16'h0000);
        send_access(CMD_READ, REG_SETRESET, 32'hFFFF_FFFF, 16'hFFFF);
        send_access(CMD_READ, REG_INDATA, 32'h0000_0000, 16'hFFFF);
        send_access(CMD_WRITE, REG_INDATA, 32'hFFFF_FFFF, 16'h0000);
        send_access(CMD_WRITE, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
        send_access(CMD_READ, 4'd10, 32'h0000_0000, 16'hFFFF);
    endtask

    task automatic test_lock_broken_sequences();
        send_access(CMD_WRITE, REG_LOCK, 32'h0001_FFFF, 16'h0000);
        // Wrong pins at the second key: the pins are taken, the sequence idles.
        send_access(CMD_WRITE, REG_LOCK, 32'h0000_0000, 16'h0000);
        send_access(CMD_WRITE, REG_LOCK, 32'hFFFE_5A5A, 16'h0000);
        send_access(CMD_WRITE, REG_LOCK, 32'h0001_A5A5, 16'h0000);
        send_access(CMD_READ, REG_LOCK, 32'h0000_0000, 16'h0000);
    endtask

    task automatic test_random_unlocked();
        while (items_sent < 600)
        begin
            idle_on = !(items_sent >= 250 && items_sent < 420);
            if (chance(30))
                send_lock_attempt(1'b0);
            else
                send_random_access(1'b0);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_result_stall();
        stall_left = 60;
        repeat (40)
            send_random_access(1'b0);
    endtask

    task automatic test_sender_pause();
        wait_until_drained();
        repeat (10)
            send_random_access(1'b0);
        wait_until_drained();
    endtask

    task automatic test_lock_sequence();
        logic [15:0] pins;
        pins = 16'($urandom);
        send_access(CMD_WRITE, REG_LOCK, {15'($urandom), 1'b1, pins}, 16'h0000);
        send_access(CMD_READ, REG_OTYPE, $urandom, 16'($urandom));
        send_access(CMD_WRITE, REG_LOCK, {15'($urandom), 1'b0, pins}, 16'h0000);
        send_access(CMD_WRITE, REG_MODE, $urandom, 16'($urandom));
        send_access(CMD_WRITE, REG_LOCK, {15'($urandom), 1'b1, pins}, 16'h0000);
        send_access(CMD_READ, REG_INDATA, $urandom, 16'($urandom));
        send_access(CMD_READ, REG_LOCK, $urandom, 16'($urandom));
        // Once locked the lock register ignores writes.
        send_access(CMD_WRITE, REG_LOCK, 32'hFFFF_FFFF, 16'h0000);
        send_access(CMD_READ, REG_LOCK, 32'h0000_0000, 16'h0000);
    endtask

    task automatic test_random_locked();
        while (items_sent < 1175)
        begin
            if (chance(10))
                send_lock_attempt(1'b1);
            else
                send_random_access(1'b1);
        end
    endtask

    task automatic check_result();
        port_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("unexpected result, read_data", rsp_ch.read_data, '0);
        end
        else
        begin
            want = expected_results.pop_front();
            if (rsp_ch.read_data !== want.read_data)
                report_mismatch("read_data", rsp_ch.read_data, want.read_data);
            if (rsp_ch.pin_drive !== want.pin_drive)
                report_mismatch("pin_drive", 32'(rsp_ch.pin_drive), 32'(want.pin_drive));
            if (rsp_ch.lock_active !== want.lock_active)
                report_mismatch("lock_active", 32'(rsp_ch.lock_active),
                                32'(want.lock_active));
        end
    endtask

    // Result side: checks each transfer and decides ready for the next edge.
    // A requested stall is counted down here at each edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                check_result();
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && chance(IDLE_PCT))
            begin
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        mode_q       = '0;
        otype_q      = '0;
        speed_q      = '0;
        pull_q       = '0;
        altfunc_q[0] = '0;
        altfunc_q[1] = '0;
        latch_q      = '0;
        lock_pins_q  = '0;
        key_step_q   = KEY_IDLE;
        lock_on_q    = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_extremes();
        test_output_latch();
        test_lock_broken_sequences();
        test_random_unlocked();
        test_result_stall();
        test_sender_pause();
        test_lock_sequence();
        test_random_locked();

        wait_until_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
